[hw/rtl/chtg_pkg.sv]
// package for the cubic hermite trajectory generator
// shared widths and constants, no dependencies
package chtg_pkg;
  localparam int unsigned PERIOD_W = 17;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 17'd66;
  localparam logic KIND_SEGMENT = 1'b0;
  localparam logic KIND_TICK = 1'b1;
endpackage

[hw/rtl/chtg_divider.sv]
// restoring divider, one quotient bit per cycle
// depends on nothing
module chtg_divider #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quo_o
);
  localparam int unsigned CW = $clog2(W + 1);
  logic [W-1:0] quo_q, den_q;
  logic [W:0] rem_q;
  logic [CW-1:0] cnt_q;
  logic busy_q, done_q;
  logic [W:0] trial;

  // trial subtract of the shifted remainder
  always_comb trial = {rem_q[W-1:0], quo_q[W-1]} - {1'b0, den_q};

  // iteration control and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
        quo_q  <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        if (!trial[W]) begin
          rem_q <= trial;
          quo_q <= {quo_q[W-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[W-1:0], quo_q[W-1]};
          quo_q <= {quo_q[W-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

[hw/rtl/cubic_hermite_trajectory_generator.sv]
// cubic hermite trajectory generator, top level
// uses chtg_pkg and chtg_divider
//
// Segment requests (kind 0) load the start and end time, position and
// velocity; the block forms duration T, tick count floor(T / period) and
// the cubic coefficients, then emits nothing. Tick requests (kind 1) emit
// one position sample each, the last sample of a segment carries tlast.
// All products go through one shared 33x33 multiplier and all quotients
// through one shared restoring divider under a small sequencer.
// A segment with a positive duration keeps the input busy through a 64-bit
// divide, one bit per cycle; an empty segment is handled without leaving idle.
// A tick forms its sample time, divides it by the duration, forms u^2, u^3
// and the c, b and a terms, then outputs its result and returns to idle for
// the next request; with zero duration the divide is skipped.
// s_axis_tready is high only in the idle state. A result sits in the
// output register until taken; the block keeps taking requests meanwhile,
// and a tick that reaches its output step while the register is still full
// waits there, holding s_axis_tready low, until the receiver takes it.
// Reset sets the period to 66 raw units and clears all coefficients.
// tdata in:  start_time, end_time, start_position, start_velocity,
//            end_position, end_velocity (lowest bits first); tuser: kind
// tdata out: position; tlast: last
module cubic_hermite_trajectory_generator #(
  parameter int unsigned COEFF_WIDTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [16:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,  // start_time, end_time, start_position,
                                      // start_velocity, end_position, end_velocity
  input  logic         s_axis_tuser,  // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,  // position
  output logic         m_axis_tlast
);
  typedef enum logic [3:0] {
    IDLE, SEG_W0, SEG_W1, SEG_DIV, SEG_FIN,
    TK_T, TK_DIV, TK_U2, TK_U3, TK_CT, TK_BH, TK_BL, TK_AH, TK_AL, TK_OUT
  } state_e;

  state_e state_q;
  logic [16:0] period_q;
  logic signed [63:0] a_q, b_q, w0_q;
  logic signed [31:0] c_q, d_q, v0_q, v1_q, p1_q;
  logic [31:0] k_q, n_q, len_q, t_q;
  logic [31:0] u_q, u2_q, u3_q;
  logic [63:0] ph_q;
  logic signed [65:0] acc_q;
  logic [31:0] pos_q;
  logic last_q, ovalid_q, div_busy_q;

  // shared divider
  logic div_start;
  logic [63:0] div_num, div_den, div_quo;
  logic div_done;
  chtg_divider #(.W(64)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  logic [16:0] period_eff;
  assign period_eff = (period_q == '0) ? 17'd1 : period_q;

  // coefficient magnitude and fraction for the q31 scaling steps
  logic is_b;
  logic signed [63:0] coef_sel;
  logic [31:0] frac_sel;
  logic coef_neg;
  logic [63:0] coef_mag;
  assign is_b = (state_q == TK_BH) || (state_q == TK_BL);
  assign coef_sel = is_b ? b_q : a_q;
  assign frac_sel = is_b ? u2_q : u3_q;
  assign coef_neg = coef_sel[63];
  assign coef_mag = coef_neg ? 64'(-coef_sel) : 64'(coef_sel);

  // shared signed 33x33 multiplier, operand select per state
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      SEG_W0: begin mul_a = 33'(v0_q); mul_b = {1'b0, len_q}; end
      SEG_W1: begin mul_a = 33'(v1_q); mul_b = {1'b0, len_q}; end
      TK_T:   begin mul_a = {1'b0, k_q}; mul_b = {16'd0, period_eff}; end
      TK_U2:  begin mul_a = {1'b0, u_q}; mul_b = {1'b0, u_q}; end
      TK_U3:  begin mul_a = {1'b0, u2_q}; mul_b = {1'b0, u_q}; end
      TK_CT:  begin mul_a = 33'(c_q); mul_b = {1'b0, t_q}; end
      TK_BH, TK_AH: begin mul_a = {1'b0, coef_mag[63:32]}; mul_b = {1'b0, frac_sel}; end
      TK_BL, TK_AL: begin mul_a = {1'b0, coef_mag[31:0]}; mul_b = {1'b0, frac_sel}; end
      default: ;
    endcase
  end
  assign prod = mul_a * mul_b;

  // coefficient times q31 fraction from the high and low half products
  logic [65:0] q31_mag;
  logic signed [65:0] q31_term;
  assign q31_mag = {1'b0, ph_q, 1'b0} + 66'(prod[63:31]);
  assign q31_term = coef_neg ? -$signed(q31_mag) : $signed(q31_mag);

  function automatic logic signed [63:0] satc(input logic signed [65:0] x);
    logic signed [65:0] hi, lo;
    hi = (66'sd1 <<< (COEFF_WIDTH - 1)) - 66'sd1;
    lo = -hi - 66'sd1;
    if (x > hi) satc = 64'(hi);
    else if (x < lo) satc = 64'(lo);
    else satc = 64'(x);
  endfunction

  // truncating divide by 2^16 toward zero
  function automatic logic signed [65:0] tdiv16(input logic signed [65:0] x);
    tdiv16 = x[65] ? -((-x) >>> 16) : (x >>> 16);
  endfunction

  logic signed [65:0] dp;
  assign dp = 66'(p1_q) - 66'(d_q);

  logic signed [65:0] w1;
  assign w1 = tdiv16(prod);

  // sample time, clamped to the segment length
  logic [48:0] t_full;
  assign t_full = prod[48:0];

  // output saturation to the signed 32-bit range
  logic [31:0] pos_sat;
  always_comb begin
    if (acc_q > 66'sd2147483647) pos_sat = 32'h7fffffff;
    else if (acc_q < -66'sd2147483648) pos_sat = 32'h80000000;
    else pos_sat = acc_q[31:0];
  end

  logic out_fire;
  assign out_fire = (state_q == TK_OUT) && (!ovalid_q || m_axis_tready);

  assign s_axis_tready = (state_q == IDLE);
  assign div_start = (state_q == SEG_W0) || (state_q == TK_DIV && !div_busy_q);

  always_comb begin
    div_num = '0;
    div_den = '0;
    if (state_q == SEG_W0) begin
      div_num = 64'(len_q);
      div_den = 64'(period_eff);
    end else begin
      div_num = {1'b0, t_q, 31'd0};
      div_den = 64'(len_q);
    end
  end

  // sequencer, state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      period_q <= chtg_pkg::PERIOD_RESET;
      a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
      k_q <= '0; n_q <= '0; len_q <= '0;
      w0_q <= '0; v0_q <= '0; v1_q <= '0; p1_q <= '0;
      t_q <= '0; u_q <= '0; u2_q <= '0; u3_q <= '0;
      ph_q <= '0; acc_q <= '0; pos_q <= '0; last_q <= 1'b0;
      ovalid_q <= 1'b0;
      div_busy_q <= 1'b0;
    end else begin
      if (cfg_we_i) period_q <= cfg_wdata_i;
      if (out_fire) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
      case (state_q)
        IDLE: if (s_axis_tvalid && s_axis_tready) begin
          if (s_axis_tuser == chtg_pkg::KIND_SEGMENT) begin
            k_q <= '0;
            v0_q <= s_axis_tdata[127:96];
            v1_q <= s_axis_tdata[191:160];
            p1_q <= s_axis_tdata[159:128];
            d_q <= s_axis_tdata[95:64];
            if (s_axis_tdata[63:32] <= s_axis_tdata[31:0]) begin
              len_q <= '0; n_q <= '0; a_q <= '0; b_q <= '0; c_q <= '0;
            end else begin
              len_q <= s_axis_tdata[63:32] - s_axis_tdata[31:0];
              state_q <= SEG_W0;
            end
          end else begin
            u_q <= '0;
            state_q <= TK_T;
          end
        end
        SEG_W0: begin
          w0_q <= 64'(tdiv16(prod));
          state_q <= SEG_W1;
        end
        SEG_W1: begin
          acc_q <= w1;
          c_q <= v0_q;
          state_q <= SEG_DIV;
        end
        SEG_DIV: if (div_done) begin
          n_q <= div_quo[31:0];
          state_q <= SEG_FIN;
        end
        SEG_FIN: begin
          a_q <= satc(-(dp <<< 1) + 66'(w0_q) + acc_q);
          b_q <= satc(dp + (dp <<< 1) - (66'(w0_q) <<< 1) - acc_q);
          state_q <= IDLE;
        end
        TK_T: begin
          t_q <= (t_full > {17'd0, len_q}) ? len_q : t_full[31:0];
          state_q <= (len_q == '0) ? TK_U2 : TK_DIV;
        end
        TK_DIV: begin
          div_busy_q <= 1'b1;
          if (div_done) begin
            div_busy_q <= 1'b0;
            u_q <= div_quo[31:0];
            state_q <= TK_U2;
          end
        end
        TK_U2: begin u2_q <= 32'(prod >>> 31); state_q <= TK_U3; end
        TK_U3: begin u3_q <= 32'(prod >>> 31); state_q <= TK_CT; end
        TK_CT: begin acc_q <= 66'(d_q) + tdiv16(prod); state_q <= TK_BH; end
        TK_BH: begin ph_q <= prod[63:0]; state_q <= TK_BL; end
        TK_BL: begin acc_q <= acc_q + q31_term; state_q <= TK_AH; end
        TK_AH: begin ph_q <= prod[63:0]; state_q <= TK_AL; end
        TK_AL: begin acc_q <= acc_q + q31_term; state_q <= TK_OUT; end
        TK_OUT: if (out_fire) begin
          pos_q <= pos_sat;
          if (k_q + 32'd1 > n_q || k_q == 32'hffffffff) begin
            k_q <= '0; last_q <= 1'b1;
          end else begin
            k_q <= k_q + 32'd1; last_q <= 1'b0;
          end
          state_q <= IDLE;
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = pos_q;
  assign m_axis_tlast = last_q;

  // a result never appears unless a tick finished
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q) == TK_OUT) else $error("stray result");
  // no request taken while busy
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != IDLE) |-> !s_axis_tready) else $error("ready while busy");
  // counter never passes the limit at rest
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == IDLE && $past(state_q) == TK_OUT) |-> (k_q <= n_q))
    else $error("counter beyond limit");
  // a waiting result stays put until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("result changed while waiting");
endmodule
